/* hw/rtl/infix_expression_evaluator_assert.svh */
// Assertion macros shared by the expression evaluator RTL.
`ifndef INFIX_EXPRESSION_EVALUATOR_ASSERT_SVH
`define INFIX_EXPRESSION_EVALUATOR_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define IEE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define IEE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/iee_pkg.sv */
// Shared types, character codes and decode function for the expression evaluator.
package iee_pkg;

  localparam int unsigned CHAR_WIDTH   = 8;
  localparam int unsigned RESULT_WIDTH = 32;

  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_WIDTH-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_WIDTH-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_WIDTH-1:0] CHAR_STAR  = 8'h2A;
  localparam logic [CHAR_WIDTH-1:0] CHAR_SLASH = 8'h2F;
  localparam logic [CHAR_WIDTH-1:0] CHAR_EQUAL = 8'h3D;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_MUL  = 2'd1,
    OP_DIV  = 2'd2
  } term_op_t;

  typedef enum logic [2:0] {
    CH_DIGIT,
    CH_MUL,
    CH_DIV,
    CH_ADD,
    CH_SUB,
    CH_EQ,
    CH_OTHER
  } char_class_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FACTOR,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic     acc_digit;
    logic     factor_start;
    logic     op_set;
    term_op_t new_op;
    logic     term_finish;
    logic     new_neg;
    logic     emit;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic out_full;
  } dp_status_t;

  function automatic char_class_t char_class(input logic [CHAR_WIDTH-1:0] c);
    char_class_t k;
    k = CH_OTHER;
    if (c inside {[CHAR_ZERO:CHAR_NINE]}) begin
      k = CH_DIGIT;
    end else begin
      case (c)
        CHAR_STAR:  k = CH_MUL;
        CHAR_SLASH: k = CH_DIV;
        CHAR_PLUS:  k = CH_ADD;
        CHAR_MINUS: k = CH_SUB;
        CHAR_EQUAL: k = CH_EQ;
        CHAR_SPACE: k = CH_OTHER;
        default:    k = CH_OTHER;
      endcase
    end
    return k;
  endfunction

endpackage

/* hw/rtl/iee_controller.sv */
// Sequencing state machine of the expression evaluator.
module iee_controller (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [iee_pkg::CHAR_WIDTH-1:0]   character,
  input  iee_pkg::dp_status_t              status,
  output iee_pkg::dp_cmd_t                 cmd
);

  iee_pkg::ctrl_state_t state, state_next;
  iee_pkg::char_class_t kind;
  iee_pkg::char_class_t in_class;

  assign in_class = iee_pkg::char_class(character);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= iee_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // operator kind held while the factor unit runs
  always_ff @(posedge clk) begin
    if (state == iee_pkg::ST_IDLE && in_valid) begin
      kind <= in_class;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      iee_pkg::ST_IDLE: begin
        if (in_valid && in_class != iee_pkg::CH_DIGIT && in_class != iee_pkg::CH_OTHER) begin
          state_next = iee_pkg::ST_FACTOR;
        end
      end
      iee_pkg::ST_FACTOR: begin
        if (!status.busy) begin
          state_next = (kind == iee_pkg::CH_EQ) ? iee_pkg::ST_EMIT : iee_pkg::ST_IDLE;
        end
      end
      iee_pkg::ST_EMIT: begin
        if (!status.out_full) begin
          state_next = iee_pkg::ST_IDLE;
        end
      end
      default: state_next = iee_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.new_op = iee_pkg::OP_NONE;
    in_ready = 1'b0;
    case (state)
      iee_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.acc_digit    = (in_class == iee_pkg::CH_DIGIT);
          cmd.factor_start = (in_class != iee_pkg::CH_DIGIT) && (in_class != iee_pkg::CH_OTHER);
        end
      end
      iee_pkg::ST_FACTOR: begin
        if (!status.busy) begin
          case (kind)
            iee_pkg::CH_MUL: begin
              cmd.op_set = 1'b1;
              cmd.new_op = iee_pkg::OP_MUL;
            end
            iee_pkg::CH_DIV: begin
              cmd.op_set = 1'b1;
              cmd.new_op = iee_pkg::OP_DIV;
            end
            iee_pkg::CH_ADD, iee_pkg::CH_EQ: begin
              cmd.term_finish = 1'b1;
            end
            iee_pkg::CH_SUB: begin
              cmd.term_finish = 1'b1;
              cmd.new_neg     = 1'b1;
            end
            default: ;
          endcase
        end
      end
      iee_pkg::ST_EMIT: begin
        cmd.emit = !status.out_full;
      end
      default: ;
    endcase
  end

endmodule

/* hw/rtl/iee_datapath.sv */
// Evaluator registers, shift-add multiplier, restoring divider and result register.
module iee_datapath #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [iee_pkg::CHAR_WIDTH-1:0]     character,
  input  iee_pkg::dp_cmd_t                   cmd,
  output iee_pkg::dp_status_t                status,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [iee_pkg::RESULT_WIDTH-1:0]   out_value,
  output logic                               out_status
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned CW = $clog2(VALUE_WIDTH);

  logic [W-1:0]      number_acc;
  logic [W-1:0]      term;
  logic [W-1:0]      sum;
  iee_pkg::term_op_t pending_op;
  logic              neg;
  logic              derr;

  // shared iteration registers: partial product or remainder, multiplicand or
  // dividend/quotient, multiplier or divisor
  logic [W-1:0]  work_p;
  logic [W-1:0]  work_a;
  logic [W-1:0]  work_b;
  logic [CW-1:0] step_cnt;
  logic          busy;
  logic          is_div;
  logic          quot_neg;

  logic [iee_pkg::CHAR_WIDTH-1:0] digit_full;
  logic [W-1:0] acc_digit_val;
  logic [W-1:0] mul_sum;
  logic [W:0]   rem_sh;
  logic         rem_fit;
  logic [W-1:0] rem_next;
  logic [W-1:0] quot_next;
  logic [W-1:0] div_result;
  logic [W-1:0] term_mag;
  logic [W-1:0] factor_mag;
  logic         last_step;
  logic signed [W-1:0] sum_s;

  assign digit_full    = character - iee_pkg::CHAR_ZERO;
  assign acc_digit_val = (number_acc << 3) + (number_acc << 1) + W'(digit_full[3:0]);

  assign mul_sum    = work_b[0] ? (work_p + work_a) : work_p;
  assign rem_sh     = {work_p, work_a[W-1]};
  assign rem_fit    = rem_sh >= {1'b0, work_b};
  assign rem_next   = rem_fit ? W'(rem_sh - {1'b0, work_b}) : rem_sh[W-1:0];
  assign quot_next  = {work_a[W-2:0], rem_fit};
  assign div_result = quot_neg ? ({W{1'b0}} - quot_next) : quot_next;
  assign last_step  = (step_cnt == CW'(W - 1));

  assign term_mag   = term[W-1]       ? ({W{1'b0}} - term)       : term;
  assign factor_mag = number_acc[W-1] ? ({W{1'b0}} - number_acc) : number_acc;

  assign sum_s = sum;

  assign status.busy     = busy;
  assign status.out_full = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_acc <= '0;
      term       <= '0;
      sum        <= '0;
      pending_op <= iee_pkg::OP_NONE;
      neg        <= 1'b0;
      derr       <= 1'b0;
      busy       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      if (cmd.acc_digit) begin
        number_acc <= acc_digit_val;
      end

      if (cmd.factor_start) begin
        number_acc <= '0;
        case (pending_op)
          iee_pkg::OP_MUL: begin
            work_p   <= '0;
            work_a   <= term;
            work_b   <= number_acc;
            is_div   <= 1'b0;
            step_cnt <= '0;
            busy     <= 1'b1;
          end
          iee_pkg::OP_DIV: begin
            if (number_acc == '0) begin
              derr <= 1'b1;
              term <= '0;
            end else begin
              work_p   <= '0;
              work_a   <= term_mag;
              work_b   <= factor_mag;
              quot_neg <= term[W-1] ^ number_acc[W-1];
              is_div   <= 1'b1;
              step_cnt <= '0;
              busy     <= 1'b1;
            end
          end
          default: begin
            term <= number_acc;
          end
        endcase
      end

      if (busy) begin
        step_cnt <= step_cnt + CW'(1);
        if (is_div) begin
          work_p <= rem_next;
          work_a <= quot_next;
        end else begin
          work_p <= mul_sum;
          work_a <= work_a << 1;
          work_b <= work_b >> 1;
        end
        if (last_step) begin
          busy <= 1'b0;
          term <= is_div ? div_result : mul_sum;
        end
      end

      if (cmd.op_set) begin
        pending_op <= cmd.new_op;
      end

      if (cmd.term_finish) begin
        sum        <= neg ? (sum - term) : (sum + term);
        term       <= '0;
        pending_op <= iee_pkg::OP_NONE;
        neg        <= cmd.new_neg;
      end

      if (cmd.emit) begin
        out_valid  <= 1'b1;
        out_status <= derr;
        out_value  <= derr ? '0 : iee_pkg::RESULT_WIDTH'(sum_s);
        number_acc <= '0;
        term       <= '0;
        sum        <= '0;
        pending_op <= iee_pkg::OP_NONE;
        neg        <= 1'b0;
        derr       <= 1'b0;
      end
    end
  end

endmodule

/* hw/rtl/infix_expression_evaluator.sv */
// Top level of the character-serial infix integer expression evaluator.
// A digit, space or unknown character is taken in the idle state; '+', '-', '*' or '/' then
//   passes the factor state, which waits for the mul/div unit if a '*' or '/' is pending
//   (mul/div retire one bit per cycle); '=' then also passes the emit state, which holds input
//   off while an earlier result waits. No new character is taken until the last is done.
// Reset (rst, synchronous, active high) clears the evaluator registers and result valid only.
module infix_expression_evaluator #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  // input character stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [iee_pkg::CHAR_WIDTH-1:0]     s_tdata,   // [7:0] character
  // result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [iee_pkg::RESULT_WIDTH-1:0]   m_tdata,   // [31:0] value (signed)
  output logic                               m_tuser    // [0] status: divide by zero
);

  iee_pkg::dp_cmd_t    cmd;
  iee_pkg::dp_status_t status;

  // controller steps through factor / term / emit phases per operator, emit only for '='
  iee_controller u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .character (s_tdata),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath holds the evaluation state and the iterative mul/div unit
  iee_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .character  (s_tdata),
    .cmd        (cmd),
    .status     (status),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_value  (m_tdata),
    .out_status (m_tuser)
  );

`include "infix_expression_evaluator_assert.svh"

  // a new request is never taken while the mul/div unit is still iterating
  `IEE_ASSERT_IMPL(a_no_accept_busy, s_tready, !status.busy, "request accepted while unit busy")
  // a result that is still waiting is never overwritten
  `IEE_ASSERT_IMPL(a_no_overwrite, cmd.emit, !(m_tvalid && !m_tready), "pending result overwritten")
  // an emit always shows up as a valid result next cycle
  `IEE_ASSERT_NEXT(a_emit_valid, cmd.emit, m_tvalid, "emit did not raise result valid")
  // a divide-by-zero result carries value zero
  `IEE_ASSERT_IMPL(a_err_zero, m_tvalid && m_tuser, m_tdata == '0, "error result not zero")

endmodule
